// ----- sv/bpm_pkg.sv -----
// ----------------------------------------------------------------------------
// bpm_pkg
// Widths and constants for the busy percent monitor.
// ----------------------------------------------------------------------------
package bpm_pkg;

    localparam int DATA_W    = 64;
    localparam int LOAD_W    = 7;
    localparam int PRODUCT_W = 71;
    localparam int CNT_W     = 7;

    localparam logic [LOAD_W-1:0] PCT_SCALE = 7'd100;
    localparam logic [CNT_W-1:0]  DIV_LAST  = 7'(PRODUCT_W - 1);

    typedef logic [DATA_W-1:0]    t_data;
    typedef logic [PRODUCT_W-1:0] t_prod;
    typedef logic [LOAD_W-1:0]    t_load;

endpackage

// ----- sv/busy_percent_monitor_top.sv -----
// ----------------------------------------------------------------------------
// busy_percent_monitor_top
// Busy share of one core over the interval between two samples, in percent.
// ----------------------------------------------------------------------------
// Each input beat is one sample of the free-running counter and the idle
// task's cumulative cycle total. The block subtracts the values kept from the
// previous sample, forms 100 * busy with two shift-adds and divides it by the
// elapsed count with a restoring divider, one quotient bit per cycle, all
// through one shared 71-bit adder. A sample whose result goes through the
// divider runs S_SPAN, S_IDLD, S_CMP, S_MUL1, S_MUL2, S_DIV and S_DONE; the
// input stalls until the block is back in S_IDLE, so a new sample waits until
// the last one is through. The first sample after reset, a zero interval, and
// idle time above the elapsed time skip the divider and give 0. A finished
// result waits in the output register while the next sample is accepted.
// ----------------------------------------------------------------------------
module busy_percent_monitor_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [bpm_pkg::DATA_W-1:0] i_counter_now,
    input  logic [bpm_pkg::DATA_W-1:0] i_idle_cycles,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bpm_pkg::LOAD_W-1:0] o_load_percent
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPAN,
        S_IDLD,
        S_CMP,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_DONE
    } t_state;

    t_state                   r_state;
    bpm_pkg::t_data           r_prev_counter;
    bpm_pkg::t_data           r_prev_idle;
    bpm_pkg::t_data           r_now;
    bpm_pkg::t_data           r_idle;
    bpm_pkg::t_data           r_span;
    bpm_pkg::t_data           r_idle_d;
    bpm_pkg::t_data           r_busy;
    bpm_pkg::t_data           r_rem;
    bpm_pkg::t_prod           r_prod;
    bpm_pkg::t_load           r_q;
    logic                     r_qovf;
    logic                     r_first;
    logic [bpm_pkg::CNT_W-1:0] r_cnt;
    logic                     r_ovalid;
    bpm_pkg::t_load           r_load;

    // shared adder
    bpm_pkg::t_prod           op_a;
    bpm_pkg::t_prod           op_b;
    logic                     op_sub;
    logic [bpm_pkg::PRODUCT_W:0] sum;
    logic                     carry;
    bpm_pkg::t_prod           res;
    logic [bpm_pkg::DATA_W:0] rem_sh;
    logic                     out_free;

    assign rem_sh   = {r_rem, r_prod[bpm_pkg::PRODUCT_W-1]};
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
        case (r_state)
            S_SPAN: begin
                op_a   = bpm_pkg::PRODUCT_W'(r_now);
                op_b   = bpm_pkg::PRODUCT_W'(r_prev_counter);
                op_sub = 1'b1;
            end
            S_IDLD: begin
                op_a   = bpm_pkg::PRODUCT_W'(r_idle);
                op_b   = bpm_pkg::PRODUCT_W'(r_prev_idle);
                op_sub = 1'b1;
            end
            S_CMP: begin
                op_a   = bpm_pkg::PRODUCT_W'(r_span);
                op_b   = bpm_pkg::PRODUCT_W'(r_idle_d);
                op_sub = 1'b1;
            end
            S_MUL1: begin
                op_a = bpm_pkg::PRODUCT_W'(r_busy) << 2;
                op_b = bpm_pkg::PRODUCT_W'(r_busy) << 5;
            end
            S_MUL2: begin
                op_a = r_prod;
                op_b = bpm_pkg::PRODUCT_W'(r_busy) << 6;
            end
            S_DIV: begin
                op_a   = bpm_pkg::PRODUCT_W'(rem_sh);
                op_b   = bpm_pkg::PRODUCT_W'(r_span);
                op_sub = 1'b1;
            end
            default: begin
                op_a   = '0;
                op_b   = '0;
                op_sub = 1'b0;
            end
        endcase
        sum   = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)}
              + (bpm_pkg::PRODUCT_W+1)'(op_sub);
        carry = sum[bpm_pkg::PRODUCT_W];
        res   = sum[bpm_pkg::PRODUCT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_prev_counter <= '0;
            r_prev_idle    <= '0;
            r_ovalid       <= 1'b0;
            r_first        <= 1'b0;
            r_qovf         <= 1'b0;
            r_q            <= '0;
            r_cnt          <= '0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_now   <= i_counter_now;
                        r_idle  <= i_idle_cycles;
                        r_first <= (r_prev_counter == '0);
                        r_state <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    r_span  <= res[bpm_pkg::DATA_W-1:0];
                    r_state <= S_IDLD;
                end
                S_IDLD: begin
                    r_idle_d       <= res[bpm_pkg::DATA_W-1:0];
                    r_prev_counter <= r_now;
                    r_prev_idle    <= r_idle;
                    r_state        <= S_CMP;
                end
                S_CMP: begin
                    r_busy <= res[bpm_pkg::DATA_W-1:0];
                    r_q    <= '0;
                    r_qovf <= 1'b0;
                    if (r_first || r_span == '0 || !carry) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_prod  <= res;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= res;
                    r_rem   <= '0;
                    r_cnt   <= bpm_pkg::DIV_LAST;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (carry) begin
                        r_rem <= res[bpm_pkg::DATA_W-1:0];
                    end else begin
                        r_rem <= rem_sh[bpm_pkg::DATA_W-1:0];
                    end
                    r_q    <= {r_q[bpm_pkg::LOAD_W-2:0], carry};
                    r_qovf <= r_qovf | r_q[bpm_pkg::LOAD_W-1];
                    r_prod <= r_prod << 1;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        if (r_qovf || r_q > bpm_pkg::PCT_SCALE) begin
                            r_load <= bpm_pkg::PCT_SCALE;
                        end else begin
                            r_load <= r_q;
                        end
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_load_percent = r_load;

endmodule

// ----- tb/busy_percent_monitor_top_tb.sv -----
// ----------------------------------------------------------------------------
// busy_percent_monitor_top_tb
// Self-checking bench for the busy percent monitor.
// ----------------------------------------------------------------------------
// A short table of directed samples covers the corner cases: first sample,
// zero interval, idle above elapsed, counter and idle wrap, and full-range
// values. Random samples follow. Most are well-formed runs of rising counter
// and idle totals. The rest are noise and broken runs. Both sides insert
// random gaps, with one stretch kept free of them. Each accepted sample goes
// through an in-bench predictor of the busy share. Every result beat is
// compared in order with the expected percentage.
// ----------------------------------------------------------------------------
module busy_percent_monitor_top_tb;

    typedef struct {
        bpm_pkg::t_data counter;
        bpm_pkg::t_data idle;
        bit             fixed;
        bpm_pkg::t_load want;
    } t_sample_row;

    typedef struct {
        bpm_pkg::t_load load;
        int             seq;
    } t_load_exp;

    localparam int N_DIRECTED   = 17;
    localparam int N_RANDOM     = 1700;
    localparam int QUIET_FROM   = 800;
    localparam int QUIET_TO     = 1000;
    localparam int DRAIN_CYCLES = 200;
    localparam bpm_pkg::t_data ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    bpm_pkg::t_data i_counter_now;
    bpm_pkg::t_data i_idle_cycles;
    logic           o_valid;
    logic           i_stall;
    bpm_pkg::t_load o_load_percent;

    bpm_pkg::t_data seen_counter;
    bpm_pkg::t_data seen_idle;
    t_load_exp      load_q[$];
    int             n_sent = 0;
    int             n_checked = 0;
    int             n_divided = 0;
    int             n_errors = 0;
    bit             quiet = 1'b0;
    t_sample_row    directed_rows [N_DIRECTED];

    busy_percent_monitor_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_counter_now  (i_counter_now),
        .i_idle_cycles  (i_idle_cycles),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_load_percent (o_load_percent)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task report_mismatch(input string msg);
        n_errors++;
        $display("tb: mismatch: %s", msg);
    endtask

    function bpm_pkg::t_data rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short, a few long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(16, 60);
    endfunction

    function bpm_pkg::t_load busy_share(input bpm_pkg::t_data now,
                                        input bpm_pkg::t_data idle);
        bpm_pkg::t_data span;
        bpm_pkg::t_data idle_d;
        bpm_pkg::t_prod scaled;
        bpm_pkg::t_prod quot;
        bpm_pkg::t_load pct;
        pct = '0;
        if (seen_counter != '0) begin
            span   = now - seen_counter;
            idle_d = idle - seen_idle;
            if (span != '0 && idle_d <= span) begin
                scaled = bpm_pkg::t_prod'(span - idle_d)
                       * bpm_pkg::t_prod'(bpm_pkg::PCT_SCALE);
                quot   = scaled / bpm_pkg::t_prod'(span);
                pct    = (quot > bpm_pkg::t_prod'(bpm_pkg::PCT_SCALE)) ?
                         bpm_pkg::PCT_SCALE : bpm_pkg::t_load'(quot);
                n_divided++;
            end
        end
        seen_counter = now;
        seen_idle    = idle;
        return pct;
    endfunction

    task send_sample(input bpm_pkg::t_data counter, input bpm_pkg::t_data idle,
                     input bit fixed, input bpm_pkg::t_load want);
        t_load_exp      e;
        bpm_pkg::t_load pct;
        int             gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_counter_now <= counter;
        i_idle_cycles <= idle;
        do @(posedge i_clk); while (o_stall);
        pct    = busy_share(counter, idle);
        e.load = fixed ? want : pct;
        e.seq  = n_sent;
        load_q.push_back(e);
        n_sent++;
    endtask

    initial begin : recv_stall
        int n;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                @(negedge i_clk) i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : load_check
        t_load_exp e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_checked++;
            if (load_q.size() == 0) begin
                report_mismatch($sformatf("result %0d with no sample pending",
                                          o_load_percent));
            end else begin
                e = load_q.pop_front();
                if (o_load_percent !== e.load) begin
                    report_mismatch($sformatf("sample %0d: load_percent %0d, want %0d",
                                              e.seq, o_load_percent, e.load));
                end
            end
        end
    end

    initial begin : stimulus
        bpm_pkg::t_data cnt;
        bpm_pkg::t_data idl;
        bpm_pkg::t_data delta;
        bpm_pkg::t_data step;
        int             r;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_counter_now = '0;
        i_idle_cycles = '0;
        seen_counter  = '0;
        seen_idle     = '0;
        directed_rows = '{
            '{64'd1000, 64'd0, 1'b1, 7'd0},
            '{64'd2000, 64'd500, 1'b1, 7'd50},
            '{64'd2000, 64'd600, 1'b1, 7'd0},
            '{64'd3000, 64'd600, 1'b1, 7'd100},
            '{64'd4000, 64'd2600, 1'b1, 7'd0},
            '{64'd5000, 64'd3600, 1'b1, 7'd0},
            '{64'd5003, 64'd3601, 1'b0, 7'd0},
            '{ALL_ONES, 64'd3601, 1'b0, 7'd0},
            '{64'd99, ALL_ONES, 1'b1, 7'd0},
            '{64'd199, 64'd9, 1'b0, 7'd0},
            '{64'd0, 64'd0, 1'b0, 7'd0},
            '{64'd12345, 64'd7, 1'b1, 7'd0},
            '{64'hFFFF_FFFF_FFFF_FFFE, 64'h5555_5555_5555_5555, 1'b0, 7'd0},
            '{ALL_ONES, 64'h5555_5555_5555_5555, 1'b1, 7'd100},
            '{64'h8000_0000_0000_0000, 64'hD555_5555_5555_5555, 1'b0, 7'd0},
            '{ALL_ONES, 64'hD555_5555_5555_5556, 1'b0, 7'd0},
            '{64'd6, 64'hD555_5555_5555_5558, 1'b0, 7'd0}
        };
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_sample(directed_rows[k].counter, directed_rows[k].idle,
                        directed_rows[k].fixed, directed_rows[k].want);
        end

        cnt = directed_rows[N_DIRECTED-1].counter;
        idl = directed_rows[N_DIRECTED-1].idle;
        for (int k = 0; k < N_RANDOM; k++) begin
            quiet = (k >= QUIET_FROM && k < QUIET_TO);
            r     = $urandom_range(0, 99);
            delta = rand64() >> $urandom_range(0, 63);
            if (r < 60) begin
                case ($urandom_range(0, 3))
                    0: step = '0;
                    1: step = delta;
                    default: step = (delta == '0) ? '0 : rand64() % delta;
                endcase
                cnt = cnt + delta;
                idl = idl + step;
            end else if (r < 70) begin
                // idle above elapsed
                cnt = cnt + delta;
                idl = idl + delta + bpm_pkg::t_data'($urandom_range(1, 1000));
            end else if (r < 75) begin
                idl = idl + bpm_pkg::t_data'($urandom_range(0, 1000));
            end else if (r < 78) begin
                cnt = '0;
                idl = idl + delta;
            end else begin
                cnt = rand64();
                idl = rand64();
            end
            send_sample(cnt, idl, 1'b0, '0);
        end
        quiet = 1'b0;
        @(negedge i_clk) i_valid <= 1'b0;

        while (load_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d samples sent (%0d directed), %0d results checked",
                 n_sent, N_DIRECTED, n_checked);
        $display("tb: %0d samples went through the divide path, %0d mismatches",
                 n_divided, n_errors);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : run_limit
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
